// ===== design/pts_pkg.sv =====
package pts_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] PolicyRr    = 2'd0;
  localparam logic [1:0] PolicyFcfs  = 2'd1;
  localparam logic [1:0] PolicyPrio  = 2'd2;
  // spare encoding, behaves as dynamic priority
  localparam logic [1:0] PolicySpare = 2'd3;

  localparam logic CfgPolicy  = 1'b0;
  localparam logic CfgDefPrio = 1'b1;

  localparam logic [1:0] PolicyReset  = 2'd2;
  localparam logic [6:0] DefPrioReset = 7'd60;
  localparam logic [6:0] PrioMax      = 7'd100;
  localparam logic [3:0] NiceIdle     = 4'd5;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_PICK   = 3'd2,
    CMD_SLEEP  = 3'd3,
    CMD_WAKE   = 3'd4,
    CMD_SETP   = 3'd5,
    CMD_YIELD  = 3'd6,
    CMD_FREE   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_INIT, OP_READ, OP_EVAL, OP_DIV, OP_CMP,
    OP_FREAD, OP_FWRITE, OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_READ, S_EVAL, S_DIV, S_CMP, S_FREAD, S_FWRITE, S_DONE
  } state_e;

  typedef struct packed {
    status_e     status;
    logic [6:0]  static_prio;
    logic [31:0] run_ticks;
    logic [31:0] sleep_ticks;
    logic [31:0] sleep_start;
    logic [31:0] times_picked;
    logic [31:0] created_at;
    logic [7:0]  wait_channel;
  } slot_rec_t;

  typedef struct packed {
    logic need_div;
    logic stop;
    logic last;
    logic fin;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/pts_intf.sv =====
interface pts_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [5:0] slot;
  logic [7:0] channel;
  logic [6:0] priority_req;
  modport source (output valid, command, slot, channel, priority_req, input ready);
  modport sink (input valid, command, slot, channel, priority_req, output ready);
endinterface

interface pts_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] chosen_slot;
  logic       success;
  logic [6:0] old_priority;
  logic       should_yield;
  logic [6:0] picked_dynamic_priority;
  modport source (output valid, chosen_slot, success, old_priority, should_yield,
                  picked_dynamic_priority, input ready);
  modport sink (input valid, chosen_slot, success, old_priority, should_yield,
                picked_dynamic_priority, output ready);
endinterface

interface pts_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pts_ctrl.sv =====
module pts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pts_pkg::dp_stat_t stat_i,
  output pts_pkg::dp_op_e   op_o
);

  pts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::S_IDLE:   if (in_valid_i) state_d = pts_pkg::S_INIT;
      pts_pkg::S_INIT:   state_d = pts_pkg::S_READ;
      pts_pkg::S_READ:   state_d = pts_pkg::S_EVAL;
      pts_pkg::S_EVAL: begin
        if (stat_i.need_div) state_d = pts_pkg::S_DIV;
        else if (stat_i.stop || stat_i.last)
          state_d = stat_i.fin ? pts_pkg::S_FREAD : pts_pkg::S_DONE;
        else state_d = pts_pkg::S_READ;
      end
      pts_pkg::S_DIV:    if (stat_i.div_done) state_d = pts_pkg::S_CMP;
      pts_pkg::S_CMP: begin
        if (stat_i.last) state_d = stat_i.fin ? pts_pkg::S_FREAD : pts_pkg::S_DONE;
        else state_d = pts_pkg::S_READ;
      end
      pts_pkg::S_FREAD:  state_d = pts_pkg::S_FWRITE;
      pts_pkg::S_FWRITE: state_d = pts_pkg::S_DONE;
      pts_pkg::S_DONE:   if (!stat_i.out_busy) state_d = pts_pkg::S_IDLE;
      default:           state_d = pts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = pts_pkg::OP_NONE;
    case (state_q)
      pts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = pts_pkg::OP_LATCH;
      end
      pts_pkg::S_INIT:   op_o = pts_pkg::OP_INIT;
      pts_pkg::S_READ:   op_o = pts_pkg::OP_READ;
      pts_pkg::S_EVAL:   op_o = pts_pkg::OP_EVAL;
      pts_pkg::S_DIV:    op_o = pts_pkg::OP_DIV;
      pts_pkg::S_CMP:    op_o = pts_pkg::OP_CMP;
      pts_pkg::S_FREAD:  op_o = pts_pkg::OP_FREAD;
      pts_pkg::S_FWRITE: op_o = pts_pkg::OP_FWRITE;
      pts_pkg::S_DONE:   if (!stat_i.out_busy) op_o = pts_pkg::OP_RESULT;
      default:           op_o = pts_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== design/pts_dp.sv =====
module pts_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::dp_op_e   op_i,
  output pts_pkg::dp_stat_t stat_o,
  input  logic [2:0]        command_i,
  input  logic [5:0]        slot_i,
  input  logic [7:0]        channel_i,
  input  logic [6:0]        priority_req_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [5:0]        chosen_slot_o,
  output logic              success_o,
  output logic [6:0]        old_priority_o,
  output logic              should_yield_o,
  output logic [6:0]        picked_dynamic_priority_o
);

  localparam int IdxW = pts_pkg::IdxW;
  localparam int CntW = pts_pkg::CntW;

  pts_pkg::cmd_e      cmd_q;
  logic [5:0]         slot_q;
  logic [7:0]         chan_q;
  logic [6:0]         preq_q;
  logic               slot_ok_q;
  logic [1:0]         policy_q;
  logic [6:0]         dsp_q;
  logic [31:0]        time_q;
  logic [IdxW-1:0]    rp_q;
  logic [CntW-1:0]    cnt_q;
  logic [IdxW-1:0]    ra_q;

  pts_pkg::slot_rec_t mem_q [pts_pkg::SLOT_COUNT];
  pts_pkg::slot_rec_t rdata_q;
  logic [pts_pkg::SLOT_COUNT-1:0] vld_q;

  // niceness divider, quotient is at most ten so four restoring steps suffice
  logic [36:0] num_q;
  logic [32:0] den_q;
  logic [3:0]  quo_q;
  logic        dz_q;
  logic [1:0]  dstep_q;

  logic            found_q;
  logic [IdxW-1:0] best_slot_q;
  logic [6:0]      best_dp_q;
  logic [31:0]     best_tp_q;
  logic [31:0]     best_ca_q;

  logic [5:0]  w_chosen_q;
  logic        w_ok_q;
  logic [6:0]  w_oldp_q;
  logic        w_yld_q;
  logic [6:0]  w_pdp_q;

  logic        ov_q;
  logic [5:0]  o_chosen_q;
  logic        o_ok_q;
  logic [6:0]  o_oldp_q;
  logic        o_yld_q;
  logic [6:0]  o_pdp_q;

  pts_pkg::status_e   cur_st;
  pts_pkg::slot_rec_t wd;
  logic               we;
  logic               re;
  logic [IdxW-1:0]    raddr;
  logic [IdxW-1:0]    scan_addr;
  logic [CntW-1:0]    rr_sum;
  logic               single;
  logic               used;
  logic               prio_mode;
  logic               runnable;
  logic               ev_take;
  logic               cmp_take;
  logic               ev_ok;
  logic [3:0]         nice;
  logic [8:0]         dyn9;
  logic [6:0]         dyn;
  logic [6:0]         dnew;
  logic [36:0]        dsh;
  logic [IdxW-1:0]    rp_next;
  logic [CntW-1:0]    rp_sum;

  assign cur_st    = vld_q[ra_q] ? rdata_q.status : pts_pkg::ST_UNUSED;
  assign single    = (cmd_q == pts_pkg::CMD_SLEEP) || (cmd_q == pts_pkg::CMD_SETP) ||
                     (cmd_q == pts_pkg::CMD_YIELD) || (cmd_q == pts_pkg::CMD_FREE);
  assign used      = slot_ok_q && vld_q[ra_q];
  assign prio_mode = (policy_q != pts_pkg::PolicyRr) && (policy_q != pts_pkg::PolicyFcfs);
  assign runnable  = (cur_st == pts_pkg::ST_RUNNABLE);

  assign rr_sum = {1'b0, rp_q} + cnt_q;
  always_comb begin
    if (cmd_q == pts_pkg::CMD_PICK && policy_q == pts_pkg::PolicyRr) begin
      if (rr_sum >= CntW'(pts_pkg::SLOT_COUNT))
        scan_addr = IdxW'(rr_sum - CntW'(pts_pkg::SLOT_COUNT));
      else scan_addr = rr_sum[IdxW-1:0];
    end else if (single) begin
      scan_addr = slot_q[IdxW-1:0];
    end else begin
      scan_addr = cnt_q[IdxW-1:0];
    end
  end

  assign rp_sum  = {1'b0, best_slot_q} + CntW'(1);
  assign rp_next = (rp_sum >= CntW'(pts_pkg::SLOT_COUNT)) ? '0 : rp_sum[IdxW-1:0];

  // dynamic priority from the finished division
  assign nice = dz_q ? pts_pkg::NiceIdle : quo_q;
  assign dyn9 = {2'b00, rdata_q.static_prio} + 9'd5 - {5'b00000, nice};
  always_comb begin
    if (dyn9[8]) dyn = '0;
    else if (dyn9 > {2'b00, pts_pkg::PrioMax}) dyn = pts_pkg::PrioMax;
    else dyn = dyn9[6:0];
  end
  assign dnew = (preq_q > pts_pkg::PrioMax) ? pts_pkg::PrioMax : preq_q;

  always_comb begin
    ev_take = 1'b0;
    if (cmd_q == pts_pkg::CMD_PICK && runnable) begin
      if (policy_q == pts_pkg::PolicyRr) ev_take = 1'b1;
      else if (policy_q == pts_pkg::PolicyFcfs)
        ev_take = !found_q || (best_ca_q > rdata_q.created_at);
    end
  end

  always_comb begin
    cmp_take = 1'b0;
    if (!found_q || dyn < best_dp_q) cmp_take = 1'b1;
    else if (dyn == best_dp_q) begin
      if (best_tp_q > rdata_q.times_picked) cmp_take = 1'b1;
      else if (best_tp_q == rdata_q.times_picked && best_ca_q > rdata_q.created_at)
        cmp_take = 1'b1;
    end
  end

  always_comb begin
    case (cmd_q)
      pts_pkg::CMD_SLEEP: ev_ok = used && cur_st != pts_pkg::ST_SLEEPING;
      pts_pkg::CMD_WAKE:  ev_ok = cur_st == pts_pkg::ST_SLEEPING &&
                                  rdata_q.wait_channel == chan_q;
      pts_pkg::CMD_YIELD: ev_ok = used && cur_st == pts_pkg::ST_RUNNING;
      pts_pkg::CMD_FREE:  ev_ok = used;
      default:            ev_ok = 1'b0;
    endcase
  end

  always_comb begin
    stat_o.need_div = (cmd_q == pts_pkg::CMD_PICK && prio_mode && runnable) ||
                      (cmd_q == pts_pkg::CMD_SETP && used);
    stat_o.stop     = single ||
                      (cmd_q == pts_pkg::CMD_CREATE && cur_st == pts_pkg::ST_UNUSED) ||
                      (cmd_q == pts_pkg::CMD_PICK && policy_q == pts_pkg::PolicyRr &&
                       runnable);
    stat_o.last     = single || (cnt_q == CntW'(pts_pkg::SLOT_COUNT));
    stat_o.fin      = (cmd_q == pts_pkg::CMD_PICK) &&
                      (found_q || (op_i == pts_pkg::OP_EVAL && ev_take) ||
                       (op_i == pts_pkg::OP_CMP && cmp_take));
    stat_o.div_done = (dstep_q == 2'd0);
    stat_o.out_busy = ov_q && !out_ready_i;
  end

  // record write port
  always_comb begin
    we = 1'b0;
    wd = rdata_q;
    case (op_i)
      pts_pkg::OP_EVAL: begin
        case (cmd_q)
          pts_pkg::CMD_CREATE: begin
            if (cur_st == pts_pkg::ST_UNUSED) begin
              we              = 1'b1;
              wd.status       = pts_pkg::ST_RUNNABLE;
              wd.static_prio  = dsp_q;
              wd.run_ticks    = '0;
              wd.sleep_ticks  = '0;
              wd.sleep_start  = '0;
              wd.times_picked = '0;
              wd.created_at   = time_q;
              wd.wait_channel = '0;
            end
          end
          pts_pkg::CMD_TICK: begin
            if (cur_st == pts_pkg::ST_RUNNING) begin
              we           = 1'b1;
              wd.run_ticks = rdata_q.run_ticks + 32'd1;
            end
          end
          pts_pkg::CMD_SLEEP: begin
            we              = ev_ok;
            wd.status       = pts_pkg::ST_SLEEPING;
            wd.wait_channel = chan_q;
            wd.sleep_start  = time_q;
          end
          pts_pkg::CMD_WAKE: begin
            we             = ev_ok;
            wd.status      = pts_pkg::ST_RUNNABLE;
            wd.sleep_ticks = time_q - rdata_q.sleep_start;
          end
          pts_pkg::CMD_YIELD: begin
            we        = ev_ok;
            wd.status = pts_pkg::ST_RUNNABLE;
          end
          default: we = 1'b0;
        endcase
      end
      pts_pkg::OP_CMP: begin
        if (cmd_q == pts_pkg::CMD_SETP) begin
          we             = 1'b1;
          wd.static_prio = preq_q;
          wd.run_ticks   = '0;
          wd.sleep_ticks = '0;
        end
      end
      pts_pkg::OP_FWRITE: begin
        we              = 1'b1;
        wd.status       = pts_pkg::ST_RUNNING;
        wd.times_picked = rdata_q.times_picked + 32'd1;
      end
      default: we = 1'b0;
    endcase
  end

  assign re    = (op_i == pts_pkg::OP_READ) || (op_i == pts_pkg::OP_FREAD);
  assign raddr = (op_i == pts_pkg::OP_FREAD) ? best_slot_q : scan_addr;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[ra_q] <= wd;
    if (re) rdata_q <= mem_q[raddr];
  end

  assign dsh = {4'b0000, den_q} << dstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pts_pkg::PolicyReset;
      dsp_q    <= pts_pkg::DefPrioReset;
      time_q   <= '0;
      rp_q     <= '0;
      vld_q    <= '0;
      ov_q     <= 1'b0;
      cnt_q    <= '0;
      dstep_q  <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == pts_pkg::CfgPolicy) policy_q <= cfg_data_i[1:0];
        else dsp_q <= cfg_data_i;
      end
      if (op_i == pts_pkg::OP_RESULT) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (op_i)
        pts_pkg::OP_INIT: begin
          cnt_q   <= '0;
          found_q <= 1'b0;
          if (cmd_q == pts_pkg::CMD_TICK) time_q <= time_q + 32'd1;
        end
        pts_pkg::OP_READ: cnt_q <= cnt_q + CntW'(1);
        pts_pkg::OP_EVAL: begin
          if (cmd_q == pts_pkg::CMD_CREATE && cur_st == pts_pkg::ST_UNUSED)
            vld_q[ra_q] <= 1'b1;
          if (cmd_q == pts_pkg::CMD_FREE && used) vld_q[ra_q] <= 1'b0;
          if (ev_take) found_q <= 1'b1;
          if (stat_o.need_div) dstep_q <= 2'd3;
        end
        pts_pkg::OP_DIV: dstep_q <= dstep_q - 2'd1;
        pts_pkg::OP_CMP: if (cmd_q == pts_pkg::CMD_PICK && cmp_take) found_q <= 1'b1;
        pts_pkg::OP_FWRITE: if (policy_q == pts_pkg::PolicyRr) rp_q <= rp_next;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      pts_pkg::OP_LATCH: begin
        cmd_q     <= pts_pkg::cmd_e'(command_i);
        slot_q    <= slot_i;
        chan_q    <= channel_i;
        preq_q    <= priority_req_i;
        slot_ok_q <= {1'b0, slot_i} < 7'(pts_pkg::SLOT_COUNT);
      end
      pts_pkg::OP_INIT: begin
        w_chosen_q <= '0;
        w_ok_q     <= 1'b0;
        w_oldp_q   <= '0;
        w_yld_q    <= 1'b0;
        w_pdp_q    <= '0;
      end
      pts_pkg::OP_READ: ra_q <= scan_addr;
      pts_pkg::OP_EVAL: begin
        if (cmd_q == pts_pkg::CMD_CREATE && cur_st == pts_pkg::ST_UNUSED) begin
          w_chosen_q <= 6'(ra_q);
          w_ok_q     <= 1'b1;
        end
        if (ev_ok) w_ok_q <= 1'b1;
        if (ev_take) begin
          best_slot_q <= ra_q;
          best_ca_q   <= rdata_q.created_at;
        end
        if (stat_o.need_div) begin
          num_q <= {2'b00, rdata_q.sleep_ticks, 3'b000} +
                   {4'b0000, rdata_q.sleep_ticks, 1'b0};
          den_q <= {1'b0, rdata_q.run_ticks} + {1'b0, rdata_q.sleep_ticks};
          dz_q  <= (rdata_q.run_ticks == '0) && (rdata_q.sleep_ticks == '0);
          quo_q <= '0;
        end
      end
      pts_pkg::OP_DIV: begin
        if (num_q >= dsh) begin
          num_q          <= num_q - dsh;
          quo_q[dstep_q] <= 1'b1;
        end
      end
      pts_pkg::OP_CMP: begin
        if (cmd_q == pts_pkg::CMD_PICK) begin
          if (cmp_take) begin
            best_slot_q <= ra_q;
            best_dp_q   <= dyn;
            best_tp_q   <= rdata_q.times_picked;
            best_ca_q   <= rdata_q.created_at;
          end
        end else begin
          w_oldp_q <= rdata_q.static_prio;
          w_yld_q  <= dyn > dnew;
          w_ok_q   <= 1'b1;
        end
      end
      pts_pkg::OP_FREAD: ra_q <= best_slot_q;
      pts_pkg::OP_FWRITE: begin
        w_chosen_q <= 6'(best_slot_q);
        w_ok_q     <= 1'b1;
        w_pdp_q    <= prio_mode ? best_dp_q : '0;
      end
      pts_pkg::OP_RESULT: begin
        o_chosen_q <= w_chosen_q;
        o_ok_q     <= w_ok_q;
        o_oldp_q   <= w_oldp_q;
        o_yld_q    <= w_yld_q;
        o_pdp_q    <= w_pdp_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o               = ov_q;
  assign chosen_slot_o             = o_chosen_q;
  assign success_o                 = o_ok_q;
  assign old_priority_o            = o_oldp_q;
  assign should_yield_o            = o_yld_q;
  assign picked_dynamic_priority_o = o_pdp_q;

endmodule

// ===== design/process_table_priority_scheduler.sv =====
// Task scheduler over a table of 64 slots, one command per item, one result per item.
// The slot records sit in a single-port memory with a registered read, so the block
// works on one item at a time and every slot visit passes through a read state and an
// evaluate state. Sleep, yield and free visit only the named slot, and set priority
// also waits on the four-step niceness divider. Create searches the slots up to the
// first free one. Tick, wake and pick in first come first served mode sweep the whole
// table, and pick in round robin mode stops at the first runnable slot from its pointer;
// pick in dynamic priority mode adds the divider and compare for each runnable task
// over the whole table. A result sits in an output register, and a new item is taken
// as soon as the previous one has reached it. Configuration writes are taken at once.
module process_table_priority_scheduler (
  input  logic   clk_i,
  input  logic   rst_ni,
  pts_cmd_if.sink   cmd_i,
  pts_res_if.source res_o,
  pts_cfg_if.sink   cfg_i
);

  pts_pkg::dp_op_e   op;
  pts_pkg::dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .stat_i     (stat),
    .op_o       (op)
  );

  pts_dp u_dp (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .op_i                      (op),
    .stat_o                    (stat),
    .command_i                 (cmd_i.command),
    .slot_i                    (cmd_i.slot),
    .channel_i                 (cmd_i.channel),
    .priority_req_i            (cmd_i.priority_req),
    .cfg_valid_i               (cfg_i.valid),
    .cfg_index_i               (cfg_i.index),
    .cfg_data_i                (cfg_i.data),
    .out_valid_o               (res_o.valid),
    .out_ready_i               (res_o.ready),
    .chosen_slot_o             (res_o.chosen_slot),
    .success_o                 (res_o.success),
    .old_priority_o            (res_o.old_priority),
    .should_yield_o            (res_o.should_yield),
    .picked_dynamic_priority_o (res_o.picked_dynamic_priority)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [2:0] command;
    logic [5:0] slot;
    logic [7:0] channel;
    logic [6:0] priority_req;
  } sched_cmd_t;

  typedef struct {
    logic [5:0] chosen_slot;
    logic       success;
    logic [6:0] old_priority;
    logic       should_yield;
    logic [6:0] picked_dyn;
  } sched_res_t;

  logic clk_i;
  logic rst_ni;

  pts_cmd_if cmd_if ();
  pts_res_if res_if ();
  pts_cfg_if cfg_if ();

  process_table_priority_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // shadow of the slot table
  logic [1:0]       mdl_policy;
  logic [6:0]       mdl_def_prio;
  logic [31:0]      mdl_now;
  logic [5:0]       mdl_rr_ptr;
  pts_pkg::status_e mdl_status  [pts_pkg::SLOT_COUNT];
  logic [6:0]       mdl_prio    [pts_pkg::SLOT_COUNT];
  logic [31:0]      mdl_run     [pts_pkg::SLOT_COUNT];
  logic [31:0]      mdl_slept   [pts_pkg::SLOT_COUNT];
  logic [31:0]      mdl_sl_from [pts_pkg::SLOT_COUNT];
  logic [31:0]      mdl_picks   [pts_pkg::SLOT_COUNT];
  logic [31:0]      mdl_born    [pts_pkg::SLOT_COUNT];
  logic [7:0]       mdl_chan    [pts_pkg::SLOT_COUNT];

  sched_cmd_t pending_cmds[$];
  sched_res_t expected_res[$];
  int         fail_count;
  int         cmds_taken;
  logic       cmd_took;
  logic       res_took;
  logic       hold_long;
  int         cmd_gap;
  int         res_gap;
  int         calm_left;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int clamp_prio(int v);
    if (v < 0) return 0;
    if (v > 100) return 100;
    return v;
  endfunction

  function automatic int dyn_prio(int s);
    logic [63:0] r, sl, nice;
    r  = mdl_run[s];
    sl = mdl_slept[s];
    if (r + sl == 0) nice = 5;
    else nice = (sl * 10) / (r + sl);
    return clamp_prio(int'(mdl_prio[s]) - int'(nice) + 5);
  endfunction

  function automatic int choose_task();
    int best, bdp, dp, s;
    best = -1;
    bdp = 0;
    if (mdl_policy == pts_pkg::PolicyRr) begin
      for (int i = 0; i < pts_pkg::SLOT_COUNT; i++) begin
        s = (int'(mdl_rr_ptr) + i) % pts_pkg::SLOT_COUNT;
        if (mdl_status[s] == pts_pkg::ST_RUNNABLE) begin
          best = s;
          break;
        end
      end
      if (best >= 0) mdl_rr_ptr = 6'(best + 1);
    end else if (mdl_policy == pts_pkg::PolicyFcfs) begin
      for (int i = 0; i < pts_pkg::SLOT_COUNT; i++) begin
        if (mdl_status[i] != pts_pkg::ST_RUNNABLE) continue;
        if (best < 0 || mdl_born[best] > mdl_born[i]) best = i;
      end
    end else begin
      for (int i = 0; i < pts_pkg::SLOT_COUNT; i++) begin
        if (mdl_status[i] != pts_pkg::ST_RUNNABLE) continue;
        dp = dyn_prio(i);
        if (best < 0 || dp < bdp) begin
          best = i;
          bdp = dp;
        end else if (dp == bdp) begin
          if (mdl_picks[best] > mdl_picks[i]) best = i;
          else if (mdl_picks[best] == mdl_picks[i] && mdl_born[best] > mdl_born[i])
            best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic sched_res_t schedule_step(sched_cmd_t c);
    sched_res_t r;
    int  s, b, dold, dnew;
    logic used;
    r = '{default: '0};
    s = c.slot;
    used = mdl_status[s] != pts_pkg::ST_UNUSED;
    case (pts_pkg::cmd_e'(c.command))
      pts_pkg::CMD_CREATE: begin
        for (int i = 0; i < pts_pkg::SLOT_COUNT; i++) begin
          if (mdl_status[i] == pts_pkg::ST_UNUSED) begin
            mdl_status[i] = pts_pkg::ST_RUNNABLE;
            mdl_prio[i] = mdl_def_prio;
            mdl_run[i] = '0;
            mdl_slept[i] = '0;
            mdl_sl_from[i] = '0;
            mdl_picks[i] = '0;
            mdl_born[i] = mdl_now;
            mdl_chan[i] = '0;
            r.chosen_slot = 6'(i);
            r.success = 1'b1;
            break;
          end
        end
      end
      pts_pkg::CMD_TICK: begin
        mdl_now++;
        for (int i = 0; i < pts_pkg::SLOT_COUNT; i++)
          if (mdl_status[i] == pts_pkg::ST_RUNNING) mdl_run[i]++;
      end
      pts_pkg::CMD_PICK: begin
        b = choose_task();
        if (b >= 0) begin
          if (mdl_policy >= pts_pkg::PolicyPrio) r.picked_dyn = 7'(dyn_prio(b));
          mdl_picks[b]++;
          mdl_status[b] = pts_pkg::ST_RUNNING;
          r.chosen_slot = 6'(b);
          r.success = 1'b1;
        end
      end
      pts_pkg::CMD_SLEEP: begin
        if (used && mdl_status[s] != pts_pkg::ST_SLEEPING) begin
          mdl_status[s] = pts_pkg::ST_SLEEPING;
          mdl_chan[s] = c.channel;
          mdl_sl_from[s] = mdl_now;
          r.success = 1'b1;
        end
      end
      pts_pkg::CMD_WAKE: begin
        for (int i = 0; i < pts_pkg::SLOT_COUNT; i++) begin
          if (mdl_status[i] == pts_pkg::ST_SLEEPING && mdl_chan[i] == c.channel) begin
            mdl_status[i] = pts_pkg::ST_RUNNABLE;
            mdl_slept[i] = mdl_now - mdl_sl_from[i];
            r.success = 1'b1;
          end
        end
      end
      pts_pkg::CMD_SETP: begin
        if (used) begin
          dold = dyn_prio(s);
          dnew = clamp_prio(int'(c.priority_req));
          r.old_priority = mdl_prio[s];
          mdl_prio[s] = c.priority_req;
          mdl_run[s] = '0;
          mdl_slept[s] = '0;
          r.should_yield = dold > dnew;
          r.success = 1'b1;
        end
      end
      pts_pkg::CMD_YIELD: begin
        if (used && mdl_status[s] == pts_pkg::ST_RUNNING) begin
          mdl_status[s] = pts_pkg::ST_RUNNABLE;
          r.success = 1'b1;
        end
      end
      default: begin
        if (used) begin
          mdl_status[s] = pts_pkg::ST_UNUSED;
          r.success = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && !cmd_took) begin
      end else if (cmd_gap > 0) begin
        cmd_if.valid <= 1'b0;
        cmd_gap <= cmd_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        sched_cmd_t c;
        c = pending_cmds.pop_front();
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= c.command;
        cmd_if.slot         <= c.slot;
        cmd_if.channel      <= c.channel;
        cmd_if.priority_req <= c.priority_req;
        if (calm_left > 0) begin
          calm_left <= calm_left - 1;
          cmd_gap <= 0;
        end else begin
          if ($urandom_range(0, 7) == 0) calm_left <= 20;
          cmd_gap <= $urandom_range(0, 17);
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_long) begin
        res_if.ready <= 1'b0;
      end else if (res_took) begin
        if (calm_left > 0) begin
          res_gap <= 0;
          res_if.ready <= 1'b1;
        end else begin
          int g;
          g = $urandom_range(0, 17);
          if (g == 0) begin
            res_gap <= 0;
            res_if.ready <= 1'b1;
          end else begin
            res_gap <= g - 1;
            res_if.ready <= 1'b0;
          end
        end
      end else if (res_gap > 0) begin
        res_gap <= res_gap - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cmd_took <= cmd_if.valid && cmd_if.ready;
    res_took <= res_if.valid && res_if.ready;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      sched_cmd_t c;
      c.command = cmd_if.command;
      c.slot = cmd_if.slot;
      c.channel = cmd_if.channel;
      c.priority_req = cmd_if.priority_req;
      expected_res.push_back(schedule_step(c));
      cmds_taken++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      sched_res_t w;
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        w = expected_res.pop_front();
        if (res_if.chosen_slot !== w.chosen_slot)
          report_mismatch("chosen_slot", res_if.chosen_slot, w.chosen_slot);
        if (res_if.success !== w.success)
          report_mismatch("success", res_if.success, w.success);
        if (res_if.old_priority !== w.old_priority)
          report_mismatch("old_priority", res_if.old_priority, w.old_priority);
        if (res_if.should_yield !== w.should_yield)
          report_mismatch("should_yield", res_if.should_yield, w.should_yield);
        if (res_if.picked_dynamic_priority !== w.picked_dyn)
          report_mismatch("picked_dynamic_priority", res_if.picked_dynamic_priority,
                          w.picked_dyn);
      end
    end
  end

  task automatic queue_cmd(pts_pkg::cmd_e op, int s, int ch, int p);
    sched_cmd_t c;
    c.command = op;
    c.slot = 6'(s);
    c.channel = 8'(ch);
    c.priority_req = 7'(p);
    pending_cmds.push_back(c);
  endtask

  // mostly low slots and a few channels so that commands hit live tasks
  task automatic queue_random(int n, int create_pct);
    int k, s, ch;
    pts_pkg::cmd_e op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < create_pct) op = pts_pkg::CMD_CREATE;
      else op = pts_pkg::cmd_e'($urandom_range(1, 7));
      s  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 63);
      ch = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      queue_cmd(op, s, ch, $urandom_range(0, 127));
    end
  endtask

  task automatic cfg_write(logic idx, logic [6:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == pts_pkg::CfgPolicy) mdl_policy = val[1:0];
    else mdl_def_prio = val;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !cmd_if.valid && expected_res.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.command = pts_pkg::CMD_CREATE;
    cmd_if.slot = '0;
    cmd_if.channel = '0;
    cmd_if.priority_req = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = pts_pkg::CfgPolicy;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    fail_count = 0;
    cmds_taken = 0;
    cmd_gap = 0;
    res_gap = 0;
    calm_left = 0;
    hold_long = 1'b0;
    mdl_policy = pts_pkg::PolicyReset;
    mdl_def_prio = pts_pkg::DefPrioReset;
    mdl_now = '0;
    mdl_rr_ptr = '0;
    foreach (mdl_status[i]) mdl_status[i] = pts_pkg::ST_UNUSED;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, every command, failing cases
    queue_cmd(pts_pkg::CMD_CREATE, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_CREATE, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_CREATE, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_PICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_TICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_TICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_SETP, 0, 0, 127);
    queue_cmd(pts_pkg::CMD_SETP, 1, 255, 0);
    queue_cmd(pts_pkg::CMD_SLEEP, 2, 255, 0);
    queue_cmd(pts_pkg::CMD_SLEEP, 2, 9, 0);
    queue_cmd(pts_pkg::CMD_TICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_WAKE, 0, 7, 0);
    queue_cmd(pts_pkg::CMD_WAKE, 0, 255, 0);
    queue_cmd(pts_pkg::CMD_YIELD, 1, 0, 0);
    queue_cmd(pts_pkg::CMD_YIELD, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_FREE, 63, 0, 0);
    queue_cmd(pts_pkg::CMD_SLEEP, 63, 0, 0);
    queue_cmd(pts_pkg::CMD_SETP, 40, 0, 50);
    queue_cmd(pts_pkg::CMD_YIELD, 40, 0, 0);
    queue_cmd(pts_pkg::CMD_PICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_PICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_FREE, 1, 0, 0);
    queue_cmd(pts_pkg::CMD_PICK, 0, 0, 0);
    queue_cmd(pts_pkg::CMD_CREATE, 0, 0, 0);
    drain();

    cfg_write(pts_pkg::CfgPolicy, 7'(pts_pkg::PolicyRr));
    cfg_write(pts_pkg::CfgDefPrio, 7'd0);
    queue_random(60, 25);
    drain();

    // fill the table so that create runs out of slots
    cfg_write(pts_pkg::CfgPolicy, 7'(pts_pkg::PolicyFcfs));
    cfg_write(pts_pkg::CfgDefPrio, 7'd100);
    queue_random(70, 80);
    drain();

    cfg_write(pts_pkg::CfgPolicy, 7'(pts_pkg::PolicyPrio));
    cfg_write(pts_pkg::CfgDefPrio, 7'd127);
    queue_random(60, 20);
    drain();

    cfg_write(pts_pkg::CfgPolicy, 7'(pts_pkg::PolicySpare));
    cfg_write(pts_pkg::CfgDefPrio, 7'd37);
    queue_random(60, 20);
    drain();

    repeat (500) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // receiver holds off for a long stretch while commands keep coming
  initial begin
    wait (cmds_taken >= 40);
    @(negedge clk_i);
    hold_long = 1'b1;
    repeat (1500) @(posedge clk_i);
    @(negedge clk_i);
    hold_long = 1'b0;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== process_table_priority_scheduler.f =====
design/pts_pkg.sv
design/pts_intf.sv
design/pts_ctrl.sv
design/pts_dp.sv
design/process_table_priority_scheduler.sv
verif/tb_top.sv
